// ===== rtl/core/mts_pkg.sv =====
package mts_pkg;

  localparam int DATA_W        = 32;
  localparam int FILL_W        = 11;
  localparam int STACK_DEPTH_D = 1024;

  // request codes
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // one entry of the running-maximum stack
  typedef struct packed {
    logic [FILL_W-1:0]        pos;
    logic signed [DATA_W-1:0] val;
  } max_entry_t;

  // one response beat
  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] max_value;
    logic [FILL_W-1:0]        fill_count;
  } rsp_t;

endpackage

// ===== rtl/core/mts_if.sv =====
interface mts_req_if;
  import mts_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface mts_rsp_if;
  import mts_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] max_value;
  logic [FILL_W-1:0]        fill_count;

  modport source (output valid, output status, output max_value, output fill_count,
                  input ready);
  modport sink   (input valid, input status, input max_value, input fill_count,
                  output ready);
endinterface

// ===== rtl/core/mts_max_ram.sv =====
module mts_max_ram #(
  parameter int DEPTH = mts_pkg::STACK_DEPTH_D
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  mts_pkg::max_entry_t      wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output mts_pkg::max_entry_t      rd_data
);
  import mts_pkg::*;

  max_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/core/mts_rsp_reg.sv =====
module mts_rsp_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  mts_pkg::rsp_t rsp_in,
  output logic          can_load,
  mts_rsp_if.source     rsp
);
  import mts_pkg::*;

  logic rsp_valid;
  rsp_t rsp_data;

  // slot frees up in the same cycle the held beat is taken
  assign can_load = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (can_load) begin
      rsp_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      rsp_data <= rsp_in;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_data.status;
  assign rsp.max_value  = rsp_data.max_value;
  assign rsp.fill_count = rsp_data.fill_count;
endmodule

// ===== rtl/core/max_tracking_stack.sv =====
// Channel | Dir | Payload                              | Beat
// req     | in  | req_type, value                      | push / pop / query
// rsp     | out | status, max_value, fill_count        | one per request
//
// One request per cycle while the output slot can take a response; the
// response appears in the output register in the cycle after the request beat.
// The top of the maxima stack sits in registers; the entry below it is read
// from the maxima RAM every cycle at the address set by the next count, so
// a pop that drops the top finds its successor already registered.
// Synchronous reset empties the stack; the RAM needs no clearing.
// A stalled response holds the request side only while the output slot is full.
module max_tracking_stack #(
  parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_D
) (
  input logic       clk,
  input logic       rst,
  mts_req_if.sink   req,
  mts_rsp_if.source rsp
);
  import mts_pkg::*;

  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int CW   = $clog2(STACK_DEPTH + 1);
  localparam int MAXW = (CW > FILL_W) ? CW : FILL_W;

  logic [CW-1:0]            elem_count, elem_count_next;
  logic [CW-1:0]            max_count, max_count_next;
  logic signed [DATA_W-1:0] top_val, top_val_next;
  logic [FILL_W-1:0]        top_pos, top_pos_next;

  logic       acc, can_load;
  logic       is_push, is_pop, full, empty, gain;
  logic [1:0] status;
  logic [CW-1:0]     pop_pos;
  logic [MAXW-1:0]   pop_pos_w, push_pos_w, fill_w;
  logic [FILL_W-1:0] pop_key, push_key;

  logic       ram_we;
  max_entry_t ram_wdata, ram_rdata;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] raddr_full;
  rsp_t       rsp_next;

  assign req.ready = can_load;
  assign acc       = req.valid && can_load;

  assign is_push = (req.req_type == REQ_PUSH);
  assign is_pop  = (req.req_type == REQ_POP);
  assign full    = (elem_count == CW'(STACK_DEPTH));
  assign empty   = (elem_count == '0);

  // positions are kept modulo two to the power of the fill field width
  assign pop_pos    = elem_count - CW'(1);
  assign pop_pos_w  = MAXW'(pop_pos);
  assign push_pos_w = MAXW'(elem_count);
  assign pop_key    = pop_pos_w[FILL_W-1:0];
  assign push_key   = push_pos_w[FILL_W-1:0];

  assign gain = (max_count == '0) || (req.value > top_val);

  // next-state for counts and cached top, plus status and RAM write enable
  always_comb begin
    elem_count_next = elem_count;
    max_count_next  = max_count;
    top_val_next    = top_val;
    top_pos_next    = top_pos;
    ram_we          = 1'b0;
    status          = ST_OK;
    if (is_push) begin
      if (full) begin
        status = ST_FULL;
      end else begin
        elem_count_next = elem_count + CW'(1);
        if (gain) begin
          ram_we         = acc;
          max_count_next = max_count + CW'(1);
          top_val_next   = req.value;
          top_pos_next   = push_key;
        end
      end
    end else if (is_pop) begin
      if (empty) begin
        status = ST_EMPTY;
      end else begin
        elem_count_next = pop_pos;
        if (max_count != '0 && top_pos == pop_key) begin
          max_count_next = max_count - CW'(1);
          top_val_next   = ram_rdata.val;
          top_pos_next   = ram_rdata.pos;
        end
      end
    end else begin
      if (empty) begin
        status = ST_EMPTY;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
      max_count  <= '0;
    end else if (acc) begin
      elem_count <= elem_count_next;
      max_count  <= max_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      top_val <= top_val_next;
      top_pos <= top_pos_next;
    end
  end

  // maxima RAM: write new entry at the top, read the one below the next top
  assign ram_waddr     = AW'(max_count);
  assign ram_wdata.val = req.value;
  assign ram_wdata.pos = push_key;
  assign raddr_full    = (acc ? max_count_next : max_count) - CW'(2);
  assign ram_raddr     = AW'(raddr_full);

  mts_max_ram #(
    .DEPTH (STACK_DEPTH)
  ) u_max_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // response beat
  assign fill_w              = MAXW'(elem_count_next);
  assign rsp_next.status     = status;
  assign rsp_next.fill_count = fill_w[FILL_W-1:0];
  assign rsp_next.max_value  = (elem_count_next == '0) ? '0 : top_val_next;

  mts_rsp_reg u_rsp_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (acc),
    .rsp_in   (rsp_next),
    .can_load (can_load),
    .rsp      (rsp)
  );

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    elem_count <= CW'(STACK_DEPTH) && max_count <= elem_count)
    else $error("maxima count exceeds element count");

  a_empty_match: assert property (@(posedge clk) disable iff (rst)
    (elem_count == '0) == (max_count == '0))
    else $error("maxima stack empty state disagrees with element stack");

  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    acc && is_push && !full |=> elem_count == $past(elem_count) + CW'(1))
    else $error("push did not grow the stack");

  a_pop_order: assert property (@(posedge clk) disable iff (rst)
    acc && is_pop && !empty |=> max_count == $past(max_count) ||
      max_count == $past(max_count) - CW'(1))
    else $error("pop removed more than one maxima entry");
`endif
endmodule
